// File: design/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types, constants and hash functions of the cuckoo MAC table.
// ----------------------------------------------------------------------------
package cmt_pkg;

    localparam int TOTAL_SLOTS = 128;
    localparam int MAX_HOPS    = 8;
    localparam int SEQ_SLOTS   = 16;

    localparam int MAC_W  = 48;
    localparam int SLOT_W = 7;
    localparam int ROW_W  = 6;
    localparam int CNT_W  = 8;
    localparam int HOP_W  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
    localparam int NLOG_W = $clog2(MAX_HOPS + 1);
    localparam int LOG_W  = SLOT_W + MAC_W;

    localparam int GRP_SZ = 8;
    localparam int N_GRP  = TOTAL_SLOTS / GRP_SZ;
    localparam int GIDX_W = $clog2(GRP_SZ);
    localparam int GRP_W  = $clog2(N_GRP);

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(96);
    localparam logic [CNT_W-1:0] NONE_FREE = CNT_W'(TOTAL_SLOTS);
    localparam logic [TOTAL_SLOTS-1:0] SEQ_MASK =
        (SEQ_SLOTS >= TOTAL_SLOTS) ? {TOTAL_SLOTS{1'b1}}
                                   : ((TOTAL_SLOTS'(1) << SEQ_SLOTS) - TOTAL_SLOTS'(1));

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_CAP  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_CLR  = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ROLLBACK = 3'd1,
        ST_FULL     = 3'd2,
        ST_ZERO     = 3'd3,
        ST_BADSLOT  = 3'd4,
        ST_NOFREE   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DISP,
        DP_RD_S1,
        DP_DEC,
        DP_HOP_A,
        DP_HOP_B,
        DP_UNDO,
        DP_SEQ_A,
        DP_SEQ_B,
        DP_FILL,
        DP_RD_OUT,
        DP_FF1,
        DP_FF2
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic mode;
        logic early_done;
        logic dec_done;
        logic hop_free;
        logic hop_last;
        logic undo_last;
        logic seq_valid;
        logic seq_hit;
        logic seq_last;
    } t_dp_stat;

    function automatic logic [ROW_W-1:0] fold6(input logic [MAC_W-1:0] x);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int k = 0; k < MAC_W / ROW_W; k++) begin
            r = r ^ x[k*ROW_W +: ROW_W];
        end
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] rev48(input logic [MAC_W-1:0] x);
        logic [MAC_W-1:0] r;
        for (int k = 0; k < MAC_W / 8; k++) begin
            r[(MAC_W/8-1-k)*8 +: 8] = x[k*8 +: 8];
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] hslot0(input logic [MAC_W-1:0] m);
        return {1'b0, fold6(m)};
    endfunction

    function automatic logic [SLOT_W-1:0] hslot1(input logic [MAC_W-1:0] m);
        return {1'b1, fold6(rev48(m))};
    endfunction

endpackage

// File: design/cmt_ram.sv
// ----------------------------------------------------------------------------
// cmt_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cmt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/cmt_ctrl.sv
// ----------------------------------------------------------------------------
// cmt_ctrl
// Command sequencer: steps the datapath through each table command.
// ----------------------------------------------------------------------------
module cmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cmt_pkg::t_dp_stat i_stat,
    output cmt_pkg::t_ctrl    o_ctrl,
    output logic              o_busy
);
    import cmt_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'h0001,
        S_DISP   = 13'h0002,
        S_RD_S1  = 13'h0004,
        S_DEC    = 13'h0008,
        S_HOP_A  = 13'h0010,
        S_HOP_B  = 13'h0020,
        S_UNDO   = 13'h0040,
        S_SEQ_A  = 13'h0080,
        S_SEQ_B  = 13'h0100,
        S_FILL   = 13'h0200,
        S_RD_OUT = 13'h0400,
        S_FF1    = 13'h0800,
        S_FF2    = 13'h1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl.op = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.op = DP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_ctrl.op = DP_DISP;
                unique case (i_stat.cmd)
                    CMD_ADD: begin
                        if (!i_stat.mode) n_state = S_SEQ_A;
                        else if (i_stat.early_done) n_state = S_FF1;
                        else n_state = S_RD_S1;
                    end
                    CMD_READ: n_state = i_stat.early_done ? S_FF1 : S_RD_OUT;
                    default:  n_state = S_FF1;
                endcase
            end
            S_RD_S1: begin
                o_ctrl.op = DP_RD_S1;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_ctrl.op = DP_DEC;
                n_state = i_stat.dec_done ? S_FF1 : S_HOP_A;
            end
            S_HOP_A: begin
                o_ctrl.op = DP_HOP_A;
                n_state = i_stat.hop_free ? S_FF1 : S_HOP_B;
            end
            S_HOP_B: begin
                o_ctrl.op = DP_HOP_B;
                n_state = i_stat.hop_last ? S_UNDO : S_HOP_A;
            end
            S_UNDO: begin
                o_ctrl.op = DP_UNDO;
                if (i_stat.undo_last) n_state = S_FF1;
            end
            S_SEQ_A: begin
                o_ctrl.op = DP_SEQ_A;
                if (i_stat.seq_valid) n_state = S_SEQ_B;
                else if (i_stat.seq_last) n_state = S_FILL;
            end
            S_SEQ_B: begin
                o_ctrl.op = DP_SEQ_B;
                if (i_stat.seq_hit) n_state = S_FF1;
                else if (i_stat.seq_last) n_state = S_FILL;
                else n_state = S_SEQ_A;
            end
            S_FILL: begin
                o_ctrl.op = DP_FILL;
                n_state = S_FF1;
            end
            S_RD_OUT: begin
                o_ctrl.op = DP_RD_OUT;
                n_state = S_FF1;
            end
            S_FF1: begin
                o_ctrl.op = DP_FF1;
                n_state = S_FF2;
            end
            S_FF2: begin
                o_ctrl.op = DP_FF2;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: design/cmt_dp.sv
// ----------------------------------------------------------------------------
// cmt_dp
// Table datapath: valid bits, entry RAM, undo log, counters and result.
// ----------------------------------------------------------------------------
module cmt_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cmt_pkg::t_ctrl              i_ctrl,
    output cmt_pkg::t_dp_stat           o_stat,
    input  logic [1:0]                  i_cmd,
    input  logic [cmt_pkg::MAC_W-1:0]   i_mac_in,
    input  logic [7:0]                  i_slot_index,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_index,
    input  logic [7:0]                  i_cfg_data,
    output logic                        o_done,
    output logic [2:0]                  o_status,
    output logic [cmt_pkg::SLOT_W-1:0]  o_slot_out,
    output logic [cmt_pkg::MAC_W-1:0]   o_mac_out,
    output logic [cmt_pkg::CNT_W-1:0]   o_used_count,
    output logic [cmt_pkg::CNT_W-1:0]   o_first_free
);
    import cmt_pkg::*;

    // control state
    logic                    r_mode;
    logic [CNT_W-1:0]        r_cap;
    logic [TOTAL_SLOTS-1:0]  r_valid;
    logic [CNT_W-1:0]        r_count;
    logic [NLOG_W-1:0]       r_nlog;
    logic                    r_done;

    // payload
    t_cmd                    r_cmd;
    logic [MAC_W-1:0]        r_mac;
    logic [7:0]              r_idx;
    logic [MAC_W-1:0]        r_mac0;
    logic [MAC_W-1:0]        r_cur;
    logic                    r_bank;
    logic [SLOT_W-1:0]       r_tslot;
    logic [SLOT_W-1:0]       r_seq_i;
    logic                    r_free_found;
    logic [SLOT_W-1:0]       r_free_idx;
    logic [LOG_W-1:0]        r_log [MAX_HOPS];
    t_status                 r_status;
    logic [SLOT_W-1:0]       r_slot_out;
    logic [MAC_W-1:0]        r_mac_out;
    logic [CNT_W-1:0]        r_first_free;
    logic                    r_grp_free [N_GRP];
    logic [GIDX_W-1:0]       r_grp_idx  [N_GRP];

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    logic [MAC_W-1:0]        ram_wdata;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [MAC_W-1:0]        ram_rdata;

    logic [SLOT_W-1:0]       s0, s1, hop_t;
    logic                    v0, v1, hit0, hit1;
    logic                    add_zero, add_full, rd_bad, del_bad;
    logic [NLOG_W-1:0]       nlog_m1;
    logic [LOG_W-1:0]        undo_ent;
    logic [SLOT_W-1:0]       idx7;
    logic                    idx_valid;
    logic [TOTAL_SLOTS-1:0]  occ;
    logic                    ff_any;
    logic [GRP_W-1:0]        ff_grp;
    logic [GIDX_W-1:0]       ff_sub;

    cmt_ram #(.WIDTH(MAC_W), .DEPTH(TOTAL_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s0        = hslot0(r_mac);
    assign s1        = hslot1(r_mac);
    assign hop_t     = r_bank ? hslot1(r_cur) : hslot0(r_cur);
    assign v0        = r_valid[s0];
    assign v1        = r_valid[s1];
    assign hit0      = v0 && (r_mac0 == r_mac);
    assign hit1      = v1 && (ram_rdata == r_mac);
    assign idx7      = r_idx[SLOT_W-1:0];
    assign idx_valid = r_valid[idx7];
    assign add_zero  = (r_mac == '0);
    assign add_full  = (r_count >= r_cap);
    assign del_bad   = r_mode ? (r_idx[7] || !idx_valid) : (r_idx >= 8'(SEQ_SLOTS));
    assign rd_bad    = r_mode ? (r_idx[7] || !idx_valid)
                              : ((r_idx >= 8'(SEQ_SLOTS)) || !idx_valid);
    assign nlog_m1   = r_nlog - NLOG_W'(1);
    assign undo_ent  = r_log[nlog_m1[HOP_W-1:0]];

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.mode       = r_mode;
        o_stat.early_done = (r_cmd == CMD_READ) ? rd_bad : (add_zero || add_full);
        o_stat.dec_done   = hit0 || hit1 || !v0 || !v1;
        o_stat.hop_free   = !r_valid[hop_t];
        o_stat.hop_last   = (r_nlog == NLOG_W'(MAX_HOPS - 1));
        o_stat.undo_last  = (r_nlog == NLOG_W'(1));
        o_stat.seq_valid  = r_valid[r_seq_i];
        o_stat.seq_hit    = (ram_rdata == r_mac);
        o_stat.seq_last   = (r_seq_i == SLOT_W'(SEQ_SLOTS - 1));
    end

    // RAM port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = s0;
        ram_wdata = r_mac;
        ram_raddr = s0;
        case (i_ctrl.op)
            DP_DISP: ram_raddr = (r_cmd == CMD_READ) ? idx7 : s0;
            DP_RD_S1: ram_raddr = s1;
            DP_DEC: begin
                ram_we    = !hit0 && !hit1 && (!v0 || !v1);
                ram_waddr = v0 ? s1 : s0;
            end
            DP_HOP_A: begin
                ram_raddr = hop_t;
                ram_we    = !r_valid[hop_t];
                ram_waddr = hop_t;
                ram_wdata = r_cur;
            end
            DP_HOP_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_tslot;
                ram_wdata = r_cur;
            end
            DP_UNDO: begin
                ram_we    = 1'b1;
                ram_waddr = undo_ent[LOG_W-1 -: SLOT_W];
                ram_wdata = undo_ent[MAC_W-1:0];
            end
            DP_SEQ_A: ram_raddr = r_seq_i;
            DP_FILL: begin
                ram_we    = r_free_found;
                ram_waddr = r_free_idx;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // first-free search, stage two: pick the lowest group with a hole
    always_comb begin
        ff_any = 1'b0;
        ff_grp = '0;
        ff_sub = '0;
        for (int g = N_GRP - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                ff_any = 1'b1;
                ff_grp = GRP_W'(g);
                ff_sub = r_grp_idx[g];
            end
        end
    end

    assign occ = r_mode ? r_valid : (r_valid | ~SEQ_MASK);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_cap   <= CAP_RESET;
            r_valid <= '0;
            r_count <= '0;
            r_nlog  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (i_ctrl.op == DP_FF2);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODE: r_mode <= i_cfg_data[0];
                    CFG_CAP:  r_cap  <= i_cfg_data;
                    default:  r_mode <= r_mode;
                endcase
            end
            case (i_ctrl.op)
                DP_DISP: begin
                    if (r_cmd == CMD_DEL && !del_bad) begin
                        r_valid[idx7] <= 1'b0;
                        if ((r_mode || idx_valid) && r_count != '0) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                    end
                    if (r_cmd == CMD_CLR) begin
                        r_valid <= '0;
                        r_count <= '0;
                    end
                end
                DP_DEC: begin
                    if (!hit0 && !hit1 && (!v0 || !v1)) begin
                        r_valid[v0 ? s1 : s0] <= 1'b1;
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_nlog <= '0;
                end
                DP_HOP_A: begin
                    if (!r_valid[hop_t]) begin
                        r_valid[hop_t] <= 1'b1;
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                DP_HOP_B: r_nlog <= r_nlog + NLOG_W'(1);
                DP_UNDO:  r_nlog <= nlog_m1;
                DP_FILL: begin
                    if (r_free_found) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                default: r_nlog <= r_nlog;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            DP_LOAD: begin
                r_cmd      <= t_cmd'(i_cmd);
                r_mac      <= i_mac_in;
                r_idx      <= i_slot_index;
                r_status   <= ST_OK;
                r_slot_out <= '0;
                r_mac_out  <= '0;
            end
            DP_DISP: begin
                r_seq_i      <= '0;
                r_free_found <= 1'b0;
                if (r_cmd == CMD_ADD && r_mode) begin
                    if (add_zero) r_status <= ST_ZERO;
                    else if (add_full) r_status <= ST_FULL;
                end
                if ((r_cmd == CMD_READ && rd_bad) || (r_cmd == CMD_DEL && del_bad)) begin
                    r_status <= ST_BADSLOT;
                end
            end
            DP_RD_S1: r_mac0 <= ram_rdata;
            DP_DEC: begin
                r_cur  <= r_mac;
                r_bank <= 1'b0;
                if (hit0) r_slot_out <= s0;
                else if (hit1) r_slot_out <= s1;
                else if (!v0) r_slot_out <= s0;
                else if (!v1) r_slot_out <= s1;
            end
            DP_HOP_A: begin
                r_tslot <= hop_t;
                if (!r_valid[hop_t]) r_slot_out <= s0;
            end
            DP_HOP_B: begin
                r_log[r_nlog[HOP_W-1:0]] <= {r_tslot, ram_rdata};
                r_cur  <= ram_rdata;
                r_bank <= ~r_bank;
                if (o_stat.hop_last) r_status <= ST_ROLLBACK;
            end
            DP_SEQ_A: begin
                if (!r_valid[r_seq_i]) begin
                    if (!r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_seq_i;
                    end
                    if (!o_stat.seq_last) r_seq_i <= r_seq_i + SLOT_W'(1);
                end
            end
            DP_SEQ_B: begin
                if (o_stat.seq_hit) r_slot_out <= r_seq_i;
                else if (!o_stat.seq_last) r_seq_i <= r_seq_i + SLOT_W'(1);
            end
            DP_FILL: begin
                if (r_free_found) r_slot_out <= r_free_idx;
                else r_status <= ST_NOFREE;
            end
            DP_RD_OUT: r_mac_out <= ram_rdata;
            DP_FF1: begin
                for (int g = 0; g < N_GRP; g++) begin
                    r_grp_free[g] <= ~&occ[g*GRP_SZ +: GRP_SZ];
                    r_grp_idx[g]  <= '0;
                    for (int b = GRP_SZ - 1; b >= 0; b--) begin
                        if (!occ[g*GRP_SZ + b]) r_grp_idx[g] <= GIDX_W'(b);
                    end
                end
            end
            DP_FF2: r_first_free <= ff_any ? CNT_W'({ff_grp, ff_sub}) : NONE_FREE;
            default: r_bank <= r_bank;
        endcase
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_slot_out   = r_slot_out;
    assign o_mac_out    = r_mac_out;
    assign o_used_count = r_count;
    assign o_first_free = r_first_free;

endmodule

// File: design/cuckoo_mac_table.sv
// ----------------------------------------------------------------------------
// cuckoo_mac_table
// 128-slot MAC address table, two-way cuckoo hashed or sequential.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_cmd, i_mac_in and i_slot_index with i_start;
//   the request is taken on an edge where i_start is high and o_busy low.
//   Result channel: o_done pulses for one cycle with o_status, o_slot_out,
//   o_mac_out, o_used_count and o_first_free. The receiver cannot stall;
//   the strobe is never held.
//   Config channel: i_cfg_valid with i_cfg_index (0 mode, 1 capacity limit)
//   and i_cfg_data; o_cfg_ready is always high. Write only while idle.
//   Sequencing: a cuckoo add reads and then writes the single-read entry
//   RAM for each eviction hop and writes one logged entry back per undo;
//   a sequential add reads the RAM once per occupied slot of the scanned
//   range. One request at a time; the next is taken in the cycle the
//   result strobes.
//   Reset: all slots invalid, count zero, cuckoo mode, capacity limit 96.
//   Entry RAM contents are not cleared; valid bits guard every read.
// ----------------------------------------------------------------------------
module cuckoo_mac_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_cmd,
    input  logic [cmt_pkg::MAC_W-1:0]   i_mac_in,
    input  logic [7:0]                  i_slot_index,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [7:0]                  i_cfg_data,
    output logic                        o_done,
    output logic [2:0]                  o_status,
    output logic [cmt_pkg::SLOT_W-1:0]  o_slot_out,
    output logic [cmt_pkg::MAC_W-1:0]   o_mac_out,
    output logic [cmt_pkg::CNT_W-1:0]   o_used_count,
    output logic [cmt_pkg::CNT_W-1:0]   o_first_free
);
    import cmt_pkg::*;

    t_ctrl    ctrl;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    cmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (o_busy)
    );

    cmt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_cmd        (i_cmd),
        .i_mac_in     (i_mac_in),
        .i_slot_index (i_slot_index),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_slot_out   (o_slot_out),
        .o_mac_out    (o_mac_out),
        .o_used_count (o_used_count),
        .o_first_free (o_first_free)
    );

endmodule

// File: design/cmt_checker.sv
// ----------------------------------------------------------------------------
// cmt_checker
// Port-level checks on the request and result channels of the table.
// ----------------------------------------------------------------------------
module cmt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [2:0] o_status,
    input logic [6:0] o_slot_out,
    input logic [7:0] o_used_count,
    input logic [7:0] o_first_free
);
    import cmt_pkg::*;

    // a taken request keeps the block busy in the next cycle
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request taken but block not busy");

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result strobe without a request in flight");

    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_slot_out == '0))
        else $error("failed request reports a slot");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_used_count <= 8'(TOTAL_SLOTS) && o_first_free <= 8'(TOTAL_SLOTS)))
        else $error("count or first free slot out of range");

endmodule

bind cuckoo_mac_table cmt_checker u_cmt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_slot_out   (o_slot_out),
    .o_used_count (o_used_count),
    .o_first_free (o_first_free)
);

// File: tb/cuckoo_mac_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cuckoo_mac_table_test
// Drives add, delete, clear and read requests in both lookup modes, checks
// every result against a behavioural table predictor, field by field.
// ----------------------------------------------------------------------------
module cuckoo_mac_table_test;
    import cmt_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 2000;

    typedef struct {
        t_status          status;
        logic [SLOT_W-1:0] slot;
        logic [MAC_W-1:0]  mac;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  ffree;
    } t_reply;

    typedef struct {
        t_cmd             cmd;
        logic [MAC_W-1:0] mac;
        logic [7:0]       idx;
        logic             known;
        t_status          st;
        logic [CNT_W-1:0] used;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic [1:0] i_cmd = '0;
    logic [MAC_W-1:0] i_mac_in = '0;
    logic [7:0] i_slot_index = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data = '0;
    logic o_done;
    logic [2:0] o_status;
    logic [SLOT_W-1:0] o_slot_out;
    logic [MAC_W-1:0] o_mac_out;
    logic [CNT_W-1:0] o_used_count;
    logic [CNT_W-1:0] o_first_free;

    always #2 i_clk = ~i_clk;

    cuckoo_mac_table DUT (.*);

    // predictor state
    logic             tbl_mode;
    logic [7:0]       tbl_cap;
    logic             tbl_valid [TOTAL_SLOTS];
    logic [MAC_W-1:0] tbl_mac   [TOTAL_SLOTS];
    int               tbl_count;

    t_reply pending_replies[$];
    int     errors = 0;
    int     idle_cycles = 0;
    logic   calm = 1'b0;
    logic [MAC_W-1:0] mac_pool[$];

    function automatic logic [5:0] row_hash(logic [MAC_W-1:0] x);
        logic [5:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) r ^= x[k*6 +: 6];
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] byte_swap(logic [MAC_W-1:0] x);
        logic [MAC_W-1:0] r;
        for (int k = 0; k < 6; k++) r[(5-k)*8 +: 8] = x[k*8 +: 8];
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] lowest_free_slot();
        int n;
        n = tbl_mode ? TOTAL_SLOTS : SEQ_SLOTS;
        for (int i = 0; i < n; i++) if (!tbl_valid[i]) return CNT_W'(i);
        return CNT_W'(TOTAL_SLOTS);
    endfunction

    function automatic t_status cuckoo_insert(logic [MAC_W-1:0] m,
                                              output logic [SLOT_W-1:0] slot);
        int s0, s1, t, nlog;
        logic bank;
        logic [MAC_W-1:0] cur, old;
        int log_slot[MAX_HOPS];
        logic [MAC_W-1:0] log_mac[MAX_HOPS];
        s0 = int'({1'b0, row_hash(m)});
        s1 = int'({1'b1, row_hash(byte_swap(m))});
        slot = '0;
        nlog = 0;
        bank = 1'b0;
        cur = m;
        if (m == '0) return ST_ZERO;
        if (tbl_count >= tbl_cap) return ST_FULL;
        if (tbl_valid[s0] && tbl_mac[s0] == m) begin slot = SLOT_W'(s0); return ST_OK; end
        if (tbl_valid[s1] && tbl_mac[s1] == m) begin slot = SLOT_W'(s1); return ST_OK; end
        if (!tbl_valid[s0] || !tbl_valid[s1]) begin
            t = tbl_valid[s0] ? s1 : s0;
            tbl_valid[t] = 1'b1; tbl_mac[t] = m; tbl_count++;
            slot = SLOT_W'(t);
            return ST_OK;
        end
        for (int hop = 0; hop < MAX_HOPS; hop++) begin
            t = bank ? int'({1'b1, row_hash(byte_swap(cur))}) : int'({1'b0, row_hash(cur)});
            if (!tbl_valid[t]) begin
                tbl_valid[t] = 1'b1; tbl_mac[t] = cur; tbl_count++;
                slot = SLOT_W'(s0);
                return ST_OK;
            end
            old = tbl_mac[t];
            log_slot[nlog] = t; log_mac[nlog] = old; nlog++;
            tbl_mac[t] = cur;
            cur = old;
            bank = ~bank;
        end
        // roll back in reverse order
        while (nlog > 0) begin
            nlog--;
            tbl_mac[log_slot[nlog]] = log_mac[nlog];
        end
        return ST_ROLLBACK;
    endfunction

    function automatic t_reply predict_table(t_cmd c, logic [MAC_W-1:0] m, logic [7:0] idx);
        t_reply r;
        int lim;
        r.status = ST_OK; r.slot = '0; r.mac = '0;
        case (c)
            CMD_ADD: begin
                if (tbl_mode) r.status = cuckoo_insert(m, r.slot);
                else begin
                    r.status = ST_NOFREE;
                    for (int i = 0; i < SEQ_SLOTS && r.status != ST_OK; i++)
                        if (tbl_valid[i] && tbl_mac[i] == m) begin
                            r.slot = SLOT_W'(i); r.status = ST_OK;
                        end
                    for (int i = 0; i < SEQ_SLOTS && r.status != ST_OK; i++)
                        if (!tbl_valid[i]) begin
                            tbl_valid[i] = 1'b1; tbl_mac[i] = m; tbl_count++;
                            r.slot = SLOT_W'(i); r.status = ST_OK;
                        end
                end
                if (r.status != ST_OK) r.slot = '0;
            end
            CMD_DEL: begin
                if (tbl_mode) begin
                    if (idx >= TOTAL_SLOTS || !tbl_valid[idx]) r.status = ST_BADSLOT;
                    else begin
                        tbl_valid[idx] = 1'b0; tbl_mac[idx] = '0;
                        if (tbl_count > 0) tbl_count--;
                    end
                end else begin
                    if (idx >= SEQ_SLOTS) r.status = ST_BADSLOT;
                    else begin
                        if (tbl_valid[idx] && tbl_count > 0) tbl_count--;
                        tbl_valid[idx] = 1'b0;
                    end
                end
            end
            CMD_CLR: begin
                for (int i = 0; i < TOTAL_SLOTS; i++) tbl_valid[i] = 1'b0;
                tbl_count = 0;
            end
            default: begin
                lim = tbl_mode ? TOTAL_SLOTS : SEQ_SLOTS;
                if (idx >= lim || !tbl_valid[idx]) r.status = ST_BADSLOT;
                else r.mac = tbl_mac[idx];
            end
        endcase
        r.used = CNT_W'(tbl_count);
        r.ffree = lowest_free_slot();
        return r;
    endfunction

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result, status %0d", o_status);
                errors++;
            end else begin
                t_reply e;
                e = pending_replies.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status); errors++;
                end
                if (o_slot_out !== e.slot) begin
                    $error("slot_out: expected %0d, got %0d", e.slot, o_slot_out); errors++;
                end
                if (o_mac_out !== e.mac) begin
                    $error("mac_out: expected %h, got %h", e.mac, o_mac_out); errors++;
                end
                if (o_used_count !== e.used) begin
                    $error("used_count: expected %0d, got %0d", e.used, o_used_count);
                    errors++;
                end
                if (o_first_free !== e.ffree) begin
                    $error("first_free: expected %0d, got %0d", e.ffree, o_first_free);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with nothing accepted or returned
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == CFG_MODE) tbl_mode = data[0];
        else tbl_cap = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the request until taken; predict at acceptance
    task automatic send_request(t_cmd c, logic [MAC_W-1:0] m, logic [7:0] idx,
                                output t_reply r);
        while (!calm && $urandom_range(99) < 10) @(posedge i_clk);
        i_start <= 1'b1;
        i_cmd <= c;
        i_mac_in <= m;
        i_slot_index <= idx;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        r = predict_table(c, m, idx);
        pending_replies.push_back(r);
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [MAC_W-1:0] pick_mac();
        logic [MAC_W-1:0] m;
        int sel;
        sel = $urandom_range(9);
        if (sel < 4 && mac_pool.size() > 0) return mac_pool[$urandom_range(mac_pool.size() - 1)];
        if (sel == 4) return '0;
        if (sel == 5) return '1;
        m = MAC_W'({$urandom(), $urandom()});
        mac_pool.push_back(m);
        if (mac_pool.size() > 200) void'(mac_pool.pop_front());
        return m;
    endfunction

    t_row   rows[$];
    t_reply got;

    initial begin
        int r;
        t_cmd c;
        tbl_mode = 1'b1;
        tbl_cap = CAP_RESET;
        tbl_count = 0;
        for (int i = 0; i < TOTAL_SLOTS; i++) begin
            tbl_valid[i] = 1'b0; tbl_mac[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: known expectations where plain to see
        rows.push_back('{CMD_READ, '0, 8'd0, 1'b1, ST_BADSLOT, 8'd0});
        rows.push_back('{CMD_ADD, '0, 8'd0, 1'b1, ST_ZERO, 8'd0});
        rows.push_back('{CMD_ADD, '1, 8'd0, 1'b1, ST_OK, 8'd1});
        rows.push_back('{CMD_ADD, '1, 8'd0, 1'b1, ST_OK, 8'd1});
        rows.push_back('{CMD_ADD, 48'h0000_0000_0001, 8'd0, 1'b0, ST_OK, 8'd0});
        rows.push_back('{CMD_ADD, 48'h0000_0000_0040, 8'd0, 1'b0, ST_OK, 8'd0});
        rows.push_back('{CMD_ADD, 48'h0040_0000_0001, 8'd0, 1'b0, ST_OK, 8'd0});
        rows.push_back('{CMD_READ, '0, 8'd255, 1'b1, ST_BADSLOT, 8'd4});
        rows.push_back('{CMD_READ, '0, 8'd127, 1'b0, ST_OK, 8'd0});
        rows.push_back('{CMD_DEL, '0, 8'd128, 1'b1, ST_BADSLOT, 8'd4});
        rows.push_back('{CMD_DEL, '0, 8'd0, 1'b0, ST_OK, 8'd0});
        rows.push_back('{CMD_READ, '0, 8'd0, 1'b0, ST_OK, 8'd0});
        rows.push_back('{CMD_CLR, '0, 8'd0, 1'b1, ST_OK, 8'd0});
        foreach (rows[i]) begin
            send_request(rows[i].cmd, rows[i].mac, rows[i].idx, got);
            if (rows[i].known && (got.status != rows[i].st || got.used != rows[i].used)) begin
                $error("row %0d: status/used expected %0d/%0d, predicted %0d/%0d",
                       i, rows[i].st, rows[i].used, got.status, got.used);
                errors++;
            end
        end

        // random phases across modes and capacity settings
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase)
                0: begin write_reg(CFG_MODE, 8'd1); write_reg(CFG_CAP, 8'd128); end
                1: write_reg(CFG_CAP, 8'd0);
                2: begin write_reg(CFG_MODE, 8'd0); write_reg(CFG_CAP, 8'd255); end
                3: begin write_reg(CFG_MODE, 8'd1); write_reg(CFG_CAP, 8'd96); end
                4: write_reg(CFG_CAP, 8'($urandom_range(128)));
                5: write_reg(CFG_MODE, 8'd0);
                6: begin write_reg(CFG_MODE, 8'd1); write_reg(CFG_CAP, 8'd128); end
                default: write_reg(CFG_CAP, 8'd5);
            endcase
            calm = (phase == 3);
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                r = $urandom_range(99);
                if (r < 60) c = CMD_ADD;
                else if (r < 78) c = CMD_DEL;
                else if (r < 80) c = CMD_CLR;
                else c = CMD_READ;
                send_request(c, pick_mac(),
                             ($urandom_range(9) == 0) ? 8'($urandom())
                             : 8'($urandom_range(tbl_mode ? 127 : 20)), got);
            end
        end
        calm = 1'b0;
        wait_drained();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
